### hw/rtl/dda_pkg.sv
// Package for the DDA line rasterizer: widths, payload structs, state encoding
// and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package dda_pkg;

    localparam int COORD_BITS = 11;
    localparam int FRAC_BITS  = 16;
    localparam int POS_BITS   = COORD_BITS + FRAC_BITS;
    localparam int STEP_BITS  = FRAC_BITS + 2;
    localparam int QUO_BITS   = FRAC_BITS + 1;
    localparam int CNT_BITS   = $clog2(QUO_BITS);
    localparam int LEFT_BITS  = COORD_BITS + 1;

    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_STEP  = 1'b1;

    typedef struct packed {
        logic                  func;
        logic [COORD_BITS-1:0] start_x;
        logic [COORD_BITS-1:0] start_y;
        logic [COORD_BITS-1:0] end_x;
        logic [COORD_BITS-1:0] end_y;
    } t_in_item;

    typedef struct packed {
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] pixel_y;
        logic                  last_pixel;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_COMMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic div_step;
        logic commit;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic line_active;
    } t_dp_status;

endpackage

### hw/rtl/dda_datapath.sv
// DDA datapath: endpoint setup, shared-divisor restoring divider for both
// increments, position accumulators and the output register.
// Depends on dda_pkg.
`timescale 1ns / 1ps

module dda_datapath
    import dda_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_in_item   i_data,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    output t_out_item  o_data
);

    logic [POS_BITS-1:0]   r_pos_x, r_pos_y;
    logic [STEP_BITS-1:0]  r_step_x, r_step_y;
    logic [LEFT_BITS-1:0]  r_pixels_left;
    logic                  r_line_active;
    logic [COORD_BITS-1:0] r_den;
    logic [COORD_BITS:0]   r_rem_x, r_rem_y;
    logic [QUO_BITS-1:0]   r_q_x, r_q_y;
    logic                  r_neg_x, r_neg_y;
    t_out_item             r_out;

    // setup
    logic signed [COORD_BITS:0] dx, dy;
    logic [COORD_BITS:0]        ax_w, ay_w;
    logic [COORD_BITS-1:0]      ax, ay, steps;

    assign dx    = $signed({1'b0, i_data.end_x}) - $signed({1'b0, i_data.start_x});
    assign dy    = $signed({1'b0, i_data.end_y}) - $signed({1'b0, i_data.start_y});
    assign ax_w  = dx[COORD_BITS] ? -dx : dx;
    assign ay_w  = dy[COORD_BITS] ? -dy : dy;
    assign ax    = ax_w[COORD_BITS-1:0];
    assign ay    = ay_w[COORD_BITS-1:0];
    assign steps = (ax > ay) ? ax : ay;

    // divider step: compare, subtract, shift
    logic                  ge_x, ge_y;
    logic [COORD_BITS:0]   sub_x, sub_y;
    logic [COORD_BITS:0]   n_rem_x, n_rem_y;
    logic [QUO_BITS-1:0]   n_q_x, n_q_y;

    assign ge_x    = r_rem_x >= {1'b0, r_den};
    assign ge_y    = r_rem_y >= {1'b0, r_den};
    assign sub_x   = r_rem_x - (ge_x ? {1'b0, r_den} : '0);
    assign sub_y   = r_rem_y - (ge_y ? {1'b0, r_den} : '0);
    assign n_rem_x = {sub_x[COORD_BITS-1:0], 1'b0};
    assign n_rem_y = {sub_y[COORD_BITS-1:0], 1'b0};
    assign n_q_x   = {r_q_x[QUO_BITS-2:0], ge_x};
    assign n_q_y   = {r_q_y[QUO_BITS-2:0], ge_y};

    // signed increments
    logic [STEP_BITS-1:0] mag_x, mag_y, n_step_x, n_step_y;

    assign mag_x    = {1'b0, r_q_x};
    assign mag_y    = {1'b0, r_q_y};
    assign n_step_x = (r_den == '0) ? '0 : (r_neg_x ? -mag_x : mag_x);
    assign n_step_y = (r_den == '0) ? '0 : (r_neg_y ? -mag_y : mag_y);

    // rounding and advance
    localparam logic [POS_BITS-1:0] HALF = POS_BITS'(1) << (FRAC_BITS - 1);
    logic [POS_BITS-1:0] rnd_x, rnd_y, n_pos_x, n_pos_y;

    assign rnd_x   = r_pos_x + HALF;
    assign rnd_y   = r_pos_y + HALF;
    assign n_pos_x = r_pos_x + {{(POS_BITS-STEP_BITS){r_step_x[STEP_BITS-1]}}, r_step_x};
    assign n_pos_y = r_pos_y + {{(POS_BITS-STEP_BITS){r_step_y[STEP_BITS-1]}}, r_step_y};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_active <= 1'b0;
            r_pixels_left <= '0;
        end else if (i_cmd.load) begin
            r_line_active <= 1'b1;
            r_pixels_left <= {1'b0, steps} + LEFT_BITS'(1);
        end else if (i_cmd.emit) begin
            r_pixels_left <= r_pixels_left - LEFT_BITS'(1);
            if (r_pixels_left == LEFT_BITS'(1)) begin
                r_line_active <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pos_x <= {i_data.start_x, {FRAC_BITS{1'b0}}};
            r_pos_y <= {i_data.start_y, {FRAC_BITS{1'b0}}};
            r_den   <= steps;
            r_rem_x <= {1'b0, ax};
            r_rem_y <= {1'b0, ay};
            r_neg_x <= dx[COORD_BITS];
            r_neg_y <= dy[COORD_BITS];
            r_q_x   <= '0;
            r_q_y   <= '0;
        end else if (i_cmd.div_step) begin
            r_rem_x <= n_rem_x;
            r_rem_y <= n_rem_y;
            r_q_x   <= n_q_x;
            r_q_y   <= n_q_y;
        end else if (i_cmd.commit) begin
            r_step_x <= n_step_x;
            r_step_y <= n_step_y;
        end else if (i_cmd.emit) begin
            r_out.pixel_x    <= rnd_x[POS_BITS-1:FRAC_BITS];
            r_out.pixel_y    <= rnd_y[POS_BITS-1:FRAC_BITS];
            r_out.last_pixel <= (r_pixels_left == LEFT_BITS'(1));
            r_pos_x          <= n_pos_x;
            r_pos_y          <= n_pos_y;
        end
    end

    assign o_status.line_active = r_line_active;
    assign o_data               = r_out;

`ifndef NO_ASSERTIONS
    a_last_ends_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && r_pixels_left == LEFT_BITS'(1)) |=> !r_line_active)
        else $error("line still active after last pixel");

    a_active_has_pixels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line_active |-> (r_pixels_left != '0))
        else $error("active line with no pixels left");

    a_pixels_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pixels_left <= LEFT_BITS'(1 << COORD_BITS))
        else $error("pixel count above longest line");
`endif

endmodule

### hw/rtl/dda_ctrl.sv
// DDA controller: input/output handshake, divide sequencing and datapath commands.
// Depends on dda_pkg.
`timescale 1ns / 1ps

module dda_ctrl
    import dda_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       i_func,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output logic       o_in_ready,
    output logic       o_out_valid,
    output t_dp_cmd    o_cmd
);

    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(QUO_BITS - 1);

    t_state              r_state, n_state;
    logic [CNT_BITS-1:0] r_cnt, n_cnt;
    logic                r_out_valid, n_out_valid;
    logic                in_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        in_fire    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = !r_out_valid || i_out_ready;
                in_fire    = i_valid && o_in_ready;
                if (in_fire && i_func == FUNC_START) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = ST_DIVIDE;
                end else if (in_fire && i_func == FUNC_STEP && i_status.line_active) begin
                    o_cmd.emit = 1'b1;
                end
            end
            ST_DIVIDE: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + CNT_BITS'(1);
                if (r_cnt == CNT_LAST) begin
                    n_state = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef NO_ASSERTIONS
    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_in_ready)
        else $error("input ready while dividing");

    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> r_out_valid)
        else $error("emitted pixel not presented");

    a_divide_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIVIDE && r_cnt == CNT_LAST) |=> (r_state == ST_COMMIT))
        else $error("divide did not finish on the last quotient bit");
`endif

endmodule

### hw/rtl/dda_line_rasterizer.sv
// DDA line rasterizer top level: controller plus datapath, valid/ready channels.
// Start transfer: input blocked while the divider runs its divide steps and the commit.
// Step transfer: pixel in the output register in the cycle after, one pixel per cycle
// sustained while the output side takes every cycle; the output register decouples.
// Reset (synchronous, active low) clears the state machine, output valid and line.
// Depends on dda_pkg, dda_ctrl and dda_datapath.
`timescale 1ns / 1ps

module dda_line_rasterizer
    import dda_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_data
);

    t_dp_cmd    cmd;
    t_dp_status status;

    dda_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_func      (i_data.func),
        .i_out_ready (i_ready),
        .i_status    (status),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .o_cmd       (cmd)
    );

    dda_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_data   (i_data),
        .i_cmd    (cmd),
        .o_status (status),
        .o_data   (o_data)
    );

endmodule

### bench/tb_top.sv
// Testbench for dda_line_rasterizer: directed and random lines, checked pixel by pixel.
// Holds its own DDA position tracker and a queue of expected pixels; random idling on both sides.
// Depends on dda_pkg and the rasterizer RTL.
`timescale 1ns / 1ps

module tb_top;
    import dda_pkg::*;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_ready;
    t_in_item  i_data  = '0;
    logic      o_valid;
    logic      i_ready = 1'b0;
    t_out_item o_data;

    dda_line_rasterizer DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    always #4 i_clk = ~i_clk;

    int in_gap_pct    = 0;
    int out_stall_pct = 0;
    int items_sent    = 0;
    int mismatches    = 0;

    t_out_item pending_pixels[$];

    // line tracker state
    longint unsigned trk_pos_x   = 0;
    longint unsigned trk_pos_y   = 0;
    longint          trk_inc_x   = 0;
    longint          trk_inc_y   = 0;
    int unsigned     trk_left    = 0;
    bit              trk_drawing = 1'b0;

    function automatic longint slope_increment(input longint diff, input longint steps);
        longint mag;
        longint q;
        if (steps <= 0) begin
            return 0;
        end
        mag = (diff < 0) ? -diff : diff;
        q   = (mag << FRAC_BITS) / steps;
        return (diff < 0) ? -q : q;
    endfunction

    function automatic logic [COORD_BITS-1:0] nearest_coord(input longint unsigned pos);
        longint unsigned half;
        half = 64'd1 << (FRAC_BITS - 1);
        return COORD_BITS'((pos + half) >> FRAC_BITS);
    endfunction

    task automatic trace_pixel(input t_in_item it);
        longint    x0;
        longint    y0;
        longint    dx;
        longint    dy;
        longint    ax;
        longint    ay;
        longint    steps;
        t_out_item px;
        if (it.func == FUNC_START) begin
            x0 = it.start_x;
            y0 = it.start_y;
            dx = longint'(it.end_x) - x0;
            dy = longint'(it.end_y) - y0;
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            steps = (ax > ay) ? ax : ay;
            trk_pos_x   = x0 << FRAC_BITS;
            trk_pos_y   = y0 << FRAC_BITS;
            trk_inc_x   = slope_increment(dx, steps);
            trk_inc_y   = slope_increment(dy, steps);
            trk_left    = 32'(steps + 1);
            trk_drawing = 1'b1;
        end else if (trk_drawing) begin
            px.pixel_x    = nearest_coord(trk_pos_x);
            px.pixel_y    = nearest_coord(trk_pos_y);
            px.last_pixel = (trk_left == 1);
            pending_pixels.push_back(px);
            trk_pos_x = trk_pos_x + trk_inc_x;
            trk_pos_y = trk_pos_y + trk_inc_y;
            trk_left--;
            if (trk_left == 0) begin
                trk_drawing = 1'b0;
            end
        end
    endtask

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch at %0t ns: %s", $time, msg);
        end
    endtask

    // output side: random stall, then check every transfer against the oldest pixel
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= out_stall_pct);
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch($sformatf("unexpected pixel x=%0d y=%0d last=%0b",
                    o_data.pixel_x, o_data.pixel_y, o_data.last_pixel));
            end else begin
                want = pending_pixels.pop_front();
                if (o_data.pixel_x !== want.pixel_x || o_data.pixel_y !== want.pixel_y
                        || o_data.last_pixel !== want.last_pixel) begin
                    report_mismatch($sformatf(
                        "expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                        want.pixel_x, want.pixel_y, want.last_pixel,
                        o_data.pixel_x, o_data.pixel_y, o_data.last_pixel));
                end
            end
        end
    end

    task automatic send_item(input t_in_item it);
        while ($urandom_range(99) < in_gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= it;
        do @(posedge i_clk); while (!o_ready);
        trace_pixel(it);
        items_sent++;
    endtask

    function automatic t_in_item make_start(input int x0, input int y0, input int x1,
                                            input int y1);
        t_in_item it;
        it.func    = FUNC_START;
        it.start_x = COORD_BITS'(x0);
        it.start_y = COORD_BITS'(y0);
        it.end_x   = COORD_BITS'(x1);
        it.end_y   = COORD_BITS'(y1);
        return it;
    endfunction

    // coordinate fields are don't-care on a step; fill them with noise
    function automatic t_in_item random_step();
        t_in_item it;
        it.func    = FUNC_STEP;
        it.start_x = COORD_BITS'($urandom_range(2047));
        it.start_y = COORD_BITS'($urandom_range(2047));
        it.end_x   = COORD_BITS'($urandom_range(2047));
        it.end_y   = COORD_BITS'($urandom_range(2047));
        return it;
    endfunction

    function automatic int clamp_coord(input int v);
        if (v < 0) begin
            return 0;
        end
        if (v > 2047) begin
            return 2047;
        end
        return v;
    endfunction

    task automatic test_step_without_line();
        send_item(random_step());
        send_item(random_step());
    endtask

    task automatic test_zero_length();
        send_item(make_start(5, 7, 5, 7));
        send_item(random_step());
        send_item(random_step());
        send_item(make_start(2047, 2047, 2047, 2047));
        send_item(random_step());
    endtask

    task automatic test_extreme_endpoints();
        send_item(make_start(0, 0, 2047, 2047));
        send_item(random_step());
        send_item(random_step());
        send_item(make_start(2047, 0, 0, 2047));
        send_item(random_step());
        send_item(random_step());
    endtask

    task automatic test_restart_mid_line();
        send_item(make_start(100, 100, 110, 103));
        repeat (3) send_item(random_step());
        send_item(make_start(20, 30, 17, 30));
        repeat (4) send_item(random_step());
    endtask

    task automatic test_long_line();
        send_item(make_start(1727, 2047, 2047, 1800));
        repeat (321) send_item(random_step());
    endtask

    task automatic test_random_lines(input int n_items);
        int target;
        int x0;
        int y0;
        int x1;
        int y1;
        int len;
        int ax;
        int ay;
        int pix;
        int cnt;
        int pick;
        t_in_item it;
        target = items_sent + n_items;
        while (items_sent < target) begin
            if ($urandom_range(99) < 85) begin
                len = ($urandom_range(9) == 0) ? int'($urandom_range(64))
                                               : int'($urandom_range(12));
                x0 = $urandom_range(2047);
                y0 = $urandom_range(2047);
                x1 = clamp_coord(x0 + int'($urandom_range(2 * len)) - len);
                y1 = clamp_coord(y0 + int'($urandom_range(2 * len)) - len);
                if ($urandom_range(1) == 1) begin
                    x1 = clamp_coord(($urandom_range(1) == 1) ? x0 + len : x0 - len);
                end else begin
                    y1 = clamp_coord(($urandom_range(1) == 1) ? y0 + len : y0 - len);
                end
                send_item(make_start(x0, y0, x1, y1));
                ax  = (x1 > x0) ? x1 - x0 : x0 - x1;
                ay  = (y1 > y0) ? y1 - y0 : y0 - y1;
                pix = ((ax > ay) ? ax : ay) + 1;
                pick = $urandom_range(99);
                if (pick < 80) begin
                    cnt = pix;
                end else if (pick < 90) begin
                    cnt = $urandom_range(pix - 1);
                end else begin
                    cnt = pix + int'($urandom_range(3, 1));
                end
                repeat (cnt) send_item(random_step());
            end else begin
                it.func    = 1'($urandom_range(1));
                it.start_x = COORD_BITS'($urandom_range(2047));
                it.start_y = COORD_BITS'($urandom_range(2047));
                it.end_x   = COORD_BITS'($urandom_range(2047));
                it.end_y   = COORD_BITS'($urandom_range(2047));
                send_item(it);
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        in_gap_pct    = 25;
        out_stall_pct = 84;
        test_step_without_line();
        test_zero_length();
        test_extreme_endpoints();
        test_restart_mid_line();
        test_random_lines(330);

        in_gap_pct    = 84;
        out_stall_pct = 25;
        test_random_lines(330);

        in_gap_pct    = 0;
        out_stall_pct = 0;
        test_random_lines(340);
        test_long_line();

        i_valid <= 1'b0;
        while (pending_pixels.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (FRAC_BITS + 8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

### dda_line_rasterizer.f
hw/rtl/dda_pkg.sv
hw/rtl/dda_datapath.sv
hw/rtl/dda_ctrl.sv
hw/rtl/dda_line_rasterizer.sv
bench/tb_top.sv
